// ===== rtl/fbsr_pkg.sv =====
// ----------------------------------------------------------------------------
// fbsr_pkg
// shared types and constants of the framed byte stream receiver
// ----------------------------------------------------------------------------
package fbsr_pkg;

  localparam int unsigned PAYLOAD_BUFFER_BYTES_DEF = 32;
  localparam int unsigned PAGE_COUNT_DEF = 4;

  localparam logic [7:0] FRAME_HEAD = 8'hEE;
  localparam logic [7:0] FRAME_TAIL = 8'hEF;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_STORED    = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_CHECK_BAD = 3'd3,
    ST_TAIL_BAD  = 3'd4,
    ST_READ      = 3'd5
  } status_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
    logic [1:0] read_page;
    logic [4:0] read_offset;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic [1:0] stored_page;
    logic [4:0] frame_length;
    logic [7:0] read_data;
  } out_item_t;

endpackage

// ===== rtl/framed_byte_stream_receiver.sv =====
// ----------------------------------------------------------------------------
// framed_byte_stream_receiver
// head/length/payload/inverted length/tail frame parser with a ring of pages
// ----------------------------------------------------------------------------
// serial byte transfer: result registered at the transfer, valid in the next cycle
// read transfer: page store read port registered, then result registered in S_READ
// good tail byte: payload moved from the staging memory read port to the page
//   store one byte per cycle in S_COPY, then the stored result is registered
// one transfer in flight; the next is taken once the block is idle and the result slot frees
// reset clears control state and page lengths at once, no clearing pass
// ----------------------------------------------------------------------------
module framed_byte_stream_receiver #(
  parameter int unsigned PAYLOAD_BUFFER_BYTES = fbsr_pkg::PAYLOAD_BUFFER_BYTES_DEF,
  parameter int unsigned PAGE_COUNT           = fbsr_pkg::PAGE_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fbsr_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fbsr_pkg::out_item_t out_data_o
);

  localparam int unsigned LW  = $clog2(PAYLOAD_BUFFER_BYTES);
  localparam int unsigned BPW = $clog2(PAYLOAD_BUFFER_BYTES + 2);
  localparam int unsigned PW  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned SD  = PAYLOAD_BUFFER_BYTES;
  localparam int unsigned PD  = PAGE_COUNT * PAYLOAD_BUFFER_BYTES;
  localparam int unsigned AW  = $clog2(PD);
  localparam logic [AW-1:0] PAGE_BYTES_A = AW'(PAYLOAD_BUFFER_BYTES);
  localparam logic [PW-1:0] LAST_PAGE = PW'(PAGE_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_COPY
  } state_e;

  state_e              state_q;
  logic                in_frame_q;
  logic [BPW-1:0]      pos_q;
  logic [LW-1:0]       len_q;
  logic                len_ok_q;
  logic [PW-1:0]       write_page_q;
  logic [LW-1:0]       plen_q [PAGE_COUNT];
  logic                rd_ok_q;
  logic [LW-1:0]       rd_len_q;
  logic [LW-1:0]       copy_len_q;
  logic [LW-1:0]       rd_idx_q;
  logic [LW-1:0]       wr_idx_q;
  logic                pend_q;
  logic [AW-1:0]       copy_base_q;
  logic                out_valid_q;
  fbsr_pkg::out_item_t out_q;

  logic              acc;
  logic              page_ok;
  logic              off_ok;
  logic              too_long;
  logic              at_check;
  logic              at_tail;
  logic              tail_good;
  logic              copy_issue;
  logic              copy_start;
  logic              out_load;
  fbsr_pkg::status_e ser_status;
  logic              stage_wr_en;
  logic [LW-1:0]     stage_wr_addr;
  logic [7:0]        stage_rdata;
  logic              page_rd_en;
  logic [AW-1:0]     page_rd_addr;
  logic [AW-1:0]     page_wr_addr;
  logic [7:0]        page_rdata;
  logic [BPW-1:0]    pos_dec;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign acc        = in_valid_i && in_ready_o;

  assign page_ok   = 5'(in_data_i.read_page) < 5'(PAGE_COUNT);
  assign off_ok    = 9'(in_data_i.read_offset) < 9'(PAYLOAD_BUFFER_BYTES);
  assign too_long  = {1'b0, in_data_i.rx_byte} >= 9'(PAYLOAD_BUFFER_BYTES);
  assign at_check  = pos_q == (BPW'(len_q) + BPW'(1));
  assign at_tail   = pos_q == (BPW'(len_q) + BPW'(2));
  assign tail_good = (in_data_i.rx_byte == fbsr_pkg::FRAME_TAIL) && len_ok_q;
  assign pos_dec   = pos_q - BPW'(1);

  // payload byte goes to staging memory at position - 1
  assign stage_wr_en   = acc && !in_data_i.req_type && in_frame_q && (pos_q != '0)
                         && !at_check && !at_tail;
  assign stage_wr_addr = pos_dec[LW-1:0];

  assign copy_issue   = (state_q == S_COPY) && (rd_idx_q < copy_len_q);
  assign copy_start   = acc && !in_data_i.req_type && in_frame_q && at_tail && tail_good;
  assign out_load     = (acc && !in_data_i.req_type && !copy_start) || (state_q == S_READ)
                        || ((state_q == S_COPY) && !copy_issue && !pend_q);
  assign page_rd_en   = acc && in_data_i.req_type && page_ok && off_ok;
  assign page_rd_addr = AW'(in_data_i.read_page) * PAGE_BYTES_A
                        + AW'(in_data_i.read_offset);
  assign page_wr_addr = copy_base_q + AW'(wr_idx_q);

  always_comb begin
    ser_status = fbsr_pkg::ST_NONE;
    if (in_frame_q) begin
      if (pos_q == '0) begin
        if (too_long) begin
          ser_status = fbsr_pkg::ST_TOO_LONG;
        end
      end else if (at_check) begin
        if (in_data_i.rx_byte != ~(8'(len_q))) begin
          ser_status = fbsr_pkg::ST_CHECK_BAD;
        end
      end else if (at_tail && !tail_good) begin
        ser_status = fbsr_pkg::ST_TAIL_BAD;
      end
    end
  end

  fbsr_ram #(
    .DEPTH (SD),
    .WIDTH (8)
  ) u_stage_ram (
    .clk_i     (clk_i),
    .wr_en_i   (stage_wr_en),
    .wr_addr_i (stage_wr_addr),
    .wr_data_i (in_data_i.rx_byte),
    .rd_en_i   (copy_issue),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (stage_rdata)
  );

  fbsr_ram #(
    .DEPTH (PD),
    .WIDTH (8)
  ) u_page_ram (
    .clk_i     (clk_i),
    .wr_en_i   (pend_q),
    .wr_addr_i (page_wr_addr),
    .wr_data_i (stage_rdata),
    .rd_en_i   (page_rd_en),
    .rd_addr_i (page_rd_addr),
    .rd_data_o (page_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      in_frame_q   <= 1'b0;
      pos_q        <= '0;
      len_q        <= '0;
      len_ok_q     <= 1'b0;
      write_page_q <= '0;
      for (int i = 0; i < PAGE_COUNT; i++) begin
        plen_q[i] <= '0;
      end
      rd_ok_q      <= 1'b0;
      rd_len_q     <= '0;
      copy_len_q   <= '0;
      rd_idx_q     <= '0;
      wr_idx_q     <= '0;
      pend_q       <= 1'b0;
      copy_base_q  <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            if (in_data_i.req_type) begin
              rd_ok_q  <= page_ok && off_ok;
              rd_len_q <= page_ok ? plen_q[PW'(in_data_i.read_page)] : '0;
              state_q  <= S_READ;
            end else begin
              out_q <= '{status: ser_status, stored_page: 2'd0,
                         frame_length: 5'd0, read_data: 8'd0};
              if (!in_frame_q) begin
                if (in_data_i.rx_byte == fbsr_pkg::FRAME_HEAD) begin
                  in_frame_q <= 1'b1;
                  pos_q      <= '0;
                  len_q      <= '0;
                  len_ok_q   <= 1'b0;
                end
              end else if (pos_q == '0) begin
                if (too_long) begin
                  in_frame_q <= 1'b0;
                  len_q      <= '0;
                end else begin
                  len_q <= in_data_i.rx_byte[LW-1:0];
                  pos_q <= BPW'(1);
                end
              end else if (at_check) begin
                if (in_data_i.rx_byte != ~(8'(len_q))) begin
                  in_frame_q <= 1'b0;
                  pos_q      <= '0;
                  len_q      <= '0;
                  len_ok_q   <= 1'b0;
                end else begin
                  len_ok_q <= 1'b1;
                  pos_q    <= pos_q + BPW'(1);
                end
              end else if (at_tail) begin
                in_frame_q <= 1'b0;
                pos_q      <= '0;
                len_q      <= '0;
                len_ok_q   <= 1'b0;
                if (tail_good) begin
                  copy_len_q  <= len_q;
                  rd_idx_q    <= '0;
                  pend_q      <= 1'b0;
                  copy_base_q <= AW'(write_page_q) * PAGE_BYTES_A;
                  state_q     <= S_COPY;
                end
              end else begin
                pos_q <= pos_q + BPW'(1);
              end
            end
          end
        end
        S_READ: begin
          out_q <= '{status: fbsr_pkg::ST_READ, stored_page: 2'd0,
                     frame_length: 5'(rd_len_q),
                     read_data: rd_ok_q ? page_rdata : 8'd0};
          state_q <= S_IDLE;
        end
        S_COPY: begin
          pend_q <= copy_issue;
          if (copy_issue) begin
            rd_idx_q <= rd_idx_q + LW'(1);
            wr_idx_q <= rd_idx_q;
          end else if (!pend_q) begin
            plen_q[write_page_q] <= copy_len_q;
            write_page_q <= (write_page_q == LAST_PAGE) ? '0 : write_page_q + PW'(1);
            out_q <= '{status: fbsr_pkg::ST_STORED, stored_page: 2'(write_page_q),
                       frame_length: 5'(copy_len_q), read_data: 8'd0};
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pend_in_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_COPY))
    else $error("page write pending outside copy");

  a_stage_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_wr_en |-> (state_q == S_IDLE) && in_frame_q)
    else $error("staging write outside a frame");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> (pos_q <= BPW'(len_q) + BPW'(2)))
    else $error("byte position past tail");

  a_read_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_data_i.req_type |=> (state_q == S_READ) && !out_valid_q)
    else $error("read transfer without free result slot");

  a_copy_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY) |-> (rd_idx_q <= copy_len_q) && !in_ready_o)
    else $error("copy index past frame length");

endmodule

// ===== rtl/fbsr_ram.sv =====
// ----------------------------------------------------------------------------
// fbsr_ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fbsr_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
